@@ rtl/fti_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fog table interpolator package
// Field widths, command codes and the fixed logarithmic segment tables.
// ----------------------------------------------------------------------------
package fti_pkg;

   localparam int unsigned TABLE_ENTRIES = 64;
   localparam int unsigned DEPTH_W       = 16;
   localparam int unsigned FOG_W         = 8;
   localparam int unsigned SPAN_W        = 14;
   localparam int unsigned PROD_W        = 32;
   localparam int unsigned DIFF_W        = FOG_W + 1;

   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   localparam logic [FOG_W-1:0] FOG_END_VALUE = 8'd255;

   typedef logic [DEPTH_W-1:0] depth_type;
   typedef logic [SPAN_W-1:0]  span_type;
   typedef logic [FOG_W-1:0]   fog_type;

   localparam depth_type SEG_START [0:TABLE_ENTRIES-1] = '{
      16'd1,     16'd1,     16'd1,     16'd1,     16'd2,     16'd2,     16'd2,     16'd3,
      16'd4,     16'd4,     16'd5,     16'd6,     16'd8,     16'd9,     16'd11,    16'd13,
      16'd16,    16'd19,    16'd22,    16'd26,    16'd32,    16'd38,    16'd45,    16'd53,
      16'd64,    16'd76,    16'd90,    16'd107,   16'd128,   16'd152,   16'd181,   16'd215,
      16'd256,   16'd304,   16'd362,   16'd430,   16'd512,   16'd608,   16'd724,   16'd861,
      16'd1024,  16'd1217,  16'd1448,  16'd1722,  16'd2048,  16'd2435,  16'd2896,  16'd3444,
      16'd4096,  16'd4870,  16'd5792,  16'd6888,  16'd8192,  16'd9741,  16'd11585, 16'd13777,
      16'd16384, 16'd19483, 16'd23170, 16'd27554, 16'd32768, 16'd38967, 16'd46340, 16'd55108
   };

   localparam span_type SEG_SPAN [0:TABLE_ENTRIES-1] = '{
      14'd0,     14'd0,     14'd0,     14'd1,     14'd0,     14'd0,     14'd1,     14'd1,
      14'd0,     14'd1,     14'd1,     14'd2,     14'd1,     14'd2,     14'd2,     14'd3,
      14'd3,     14'd3,     14'd4,     14'd6,     14'd6,     14'd7,     14'd8,     14'd11,
      14'd12,    14'd14,    14'd17,    14'd21,    14'd24,    14'd29,    14'd34,    14'd41,
      14'd48,    14'd58,    14'd68,    14'd82,    14'd96,    14'd116,   14'd137,   14'd163,
      14'd193,   14'd231,   14'd274,   14'd326,   14'd387,   14'd461,   14'd548,   14'd652,
      14'd774,   14'd922,   14'd1096,  14'd1304,  14'd1549,  14'd1844,  14'd2192,  14'd2607,
      14'd3099,  14'd3687,  14'd4384,  14'd5214,  14'd6199,  14'd7373,  14'd8768,  14'd10428
   };

endpackage

@@ rtl/fog_table_interpolator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fog table interpolator
// Holds a 64-entry fog table and answers depth lookups by piecewise-linear
// interpolation over fixed logarithmic segments.
//
// Request words (req_*) either load one table entry (req_cmd = load) or look
// up a depth index (req_cmd = lookup). A word is taken when req_valid is high
// and req_stall is low. A load is written in the cycle it is taken and gives
// no response; the next word may follow at once. A lookup gives one response
// word (rsp_fog_value) and holds req_stall high while it works: a binary
// search over the segment starts, two reads through the table's single read
// port, the difference, the multiply, a restoring divide with one quotient bit
// a cycle, and a step that moves the result into the output register once it
// is free. req_stall drops as rsp_valid rises. Depth index zero skips the
// search and the arithmetic and goes straight to that last step, answering 0.
// The output register parts the two sides: while rsp_stall holds a response,
// loads are still taken and one further lookup runs to completion, then
// waits. Reset clears the control state and the output valid; table entries
// are undefined until loaded.
// ----------------------------------------------------------------------------
module fog_table_interpolator #(
   parameter int unsigned TABLE_ENTRIES = fti_pkg::TABLE_ENTRIES,
   localparam int unsigned IDX_W        = $clog2(TABLE_ENTRIES)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_cmd,
   input  logic [IDX_W-1:0]           req_entry_index,
   input  logic [fti_pkg::FOG_W-1:0]  req_entry_value,
   input  logic [fti_pkg::DEPTH_W-1:0] req_depth_index,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [fti_pkg::FOG_W-1:0]  rsp_fog_value
);

   localparam int unsigned FOG_W  = fti_pkg::FOG_W;
   localparam int unsigned SPAN_W = fti_pkg::SPAN_W;
   localparam int unsigned PROD_W = fti_pkg::PROD_W;
   localparam int unsigned DIFF_W = fti_pkg::DIFF_W;
   localparam int unsigned CNT_W  = $clog2(PROD_W);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SRCH = 3'd1;
   localparam logic [2:0] S_RDA  = 3'd2;
   localparam logic [2:0] S_RDB  = 3'd3;
   localparam logic [2:0] S_CAPB = 3'd4;
   localparam logic [2:0] S_MUL  = 3'd5;
   localparam logic [2:0] S_DIV  = 3'd6;
   localparam logic [2:0] S_DONE = 3'd7;

   localparam logic [IDX_W-1:0] LAST_SEG  = IDX_W'(TABLE_ENTRIES - 1);
   localparam logic [IDX_W-1:0] PROBE_TOP = IDX_W'(1) << (IDX_W - 1);
   localparam logic [CNT_W-1:0] CNT_TOP   = CNT_W'(PROD_W - 1);

   logic [FOG_W-1:0] fog_mem [0:TABLE_ENTRIES-1];

   logic [2:0]                  state_ff,   state_in;
   fti_pkg::depth_type          depth_ff,   depth_in;
   logic [IDX_W-1:0]            seg_ff,     seg_in;
   logic [IDX_W-1:0]            probe_ff,   probe_in;
   logic [FOG_W-1:0]            rd_data_ff;
   logic [FOG_W-1:0]            a_ff,       a_in;
   logic [DIFF_W-1:0]           diff_ff,    diff_in;
   fti_pkg::span_type           off_ff,     off_in;
   fti_pkg::span_type           span_ff,    span_in;
   logic [PROD_W-1:0]           quo_ff,     quo_in;
   fti_pkg::span_type           rem_ff,     rem_in;
   logic [CNT_W-1:0]            cnt_ff,     cnt_in;
   logic [FOG_W-1:0]            res_ff,     res_in;
   logic                        out_vld_ff, out_vld_in;
   logic [FOG_W-1:0]            out_fog_ff, out_fog_in;

   logic                        req_take;
   logic                        out_free;
   logic [IDX_W-1:0]            probe_idx;
   logic [IDX_W-1:0]            rd_addr;
   logic [FOG_W-1:0]            b_val;
   logic [PROD_W-1:0]           diff_ext;
   logic [PROD_W-1:0]           prod;
   logic [SPAN_W:0]             trial;
   logic                        trial_ge;
   logic [PROD_W-1:0]           quo_next;

   assign req_stall     = (state_ff != S_IDLE);
   assign req_take      = req_valid && !req_stall;
   assign out_free      = !out_vld_ff || !rsp_stall;
   assign rsp_valid     = out_vld_ff;
   assign rsp_fog_value = out_fog_ff;

   assign probe_idx = seg_ff | probe_ff;
   assign rd_addr   = (state_ff == S_RDA) ? seg_ff : seg_ff + IDX_W'(1);
   assign b_val     = (seg_ff == LAST_SEG) ? fti_pkg::FOG_END_VALUE : rd_data_ff;
   assign diff_ext  = {{(PROD_W-DIFF_W){diff_ff[DIFF_W-1]}}, diff_ff};
   assign prod      = diff_ext * {{(PROD_W-SPAN_W){1'b0}}, off_ff};
   assign trial     = {rem_ff, quo_ff[PROD_W-1]};
   assign trial_ge  = (trial >= {1'b0, span_ff});
   assign quo_next  = {quo_ff[PROD_W-2:0], trial_ge};

   always_ff @(posedge clock) begin
      if (req_take && (req_cmd == fti_pkg::CMD_LOAD)) begin
         fog_mem[req_entry_index] <= req_entry_value;
      end
      rd_data_ff <= fog_mem[rd_addr];
   end

   always_comb begin
      state_in   = state_ff;
      depth_in   = depth_ff;
      seg_in     = seg_ff;
      probe_in   = probe_ff;
      a_in       = a_ff;
      diff_in    = diff_ff;
      off_in     = off_ff;
      span_in    = span_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      cnt_in     = cnt_ff;
      res_in     = res_ff;
      out_vld_in = out_vld_ff && rsp_stall;
      out_fog_in = out_fog_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take && (req_cmd == fti_pkg::CMD_LOOKUP)) begin
               depth_in = req_depth_index;
               seg_in   = '0;
               probe_in = PROBE_TOP;
               if (req_depth_index == '0) begin
                  res_in   = '0;
                  state_in = S_DONE;
               end else begin
                  state_in = S_SRCH;
               end
            end
         end
         S_SRCH: begin
            if (fti_pkg::SEG_START[probe_idx] <= depth_ff) begin
               seg_in = probe_idx;
            end
            probe_in = probe_ff >> 1;
            if (probe_ff[0]) begin
               state_in = S_RDA;
            end
         end
         S_RDA: begin
            state_in = S_RDB;
         end
         S_RDB: begin
            a_in     = rd_data_ff;
            state_in = S_CAPB;
         end
         S_CAPB: begin
            diff_in  = {1'b0, b_val} - {1'b0, a_ff};
            off_in   = SPAN_W'(depth_ff - fti_pkg::SEG_START[seg_ff]);
            span_in  = fti_pkg::SEG_SPAN[seg_ff];
            state_in = S_MUL;
         end
         S_MUL: begin
            quo_in   = prod;
            rem_in   = '0;
            cnt_in   = CNT_TOP;
            state_in = S_DIV;
         end
         S_DIV: begin
            quo_in = quo_next;
            rem_in = trial_ge ? SPAN_W'(trial - {1'b0, span_ff}) : trial[SPAN_W-1:0];
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               res_in   = a_ff + quo_next[FOG_W-1:0];
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               out_vld_in = 1'b1;
               out_fog_in = res_ff;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         out_vld_ff <= 1'b0;
         probe_ff   <= PROBE_TOP;
      end else begin
         state_ff   <= state_in;
         out_vld_ff <= out_vld_in;
         probe_ff   <= probe_in;
      end
   end

   always_ff @(posedge clock) begin
      depth_ff   <= depth_in;
      seg_ff     <= seg_in;
      a_ff       <= a_in;
      diff_ff    <= diff_in;
      off_ff     <= off_in;
      span_ff    <= span_in;
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      cnt_ff     <= cnt_in;
      res_ff     <= res_in;
      out_fog_ff <= out_fog_in;
   end

   a_probe_onehot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SRCH) |-> $onehot(probe_ff))
      else $error("search probe bit not one-hot");

   a_seg_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CAPB) |-> (depth_ff >= fti_pkg::SEG_START[seg_ff]) &&
         ((seg_ff == LAST_SEG) || (depth_ff < fti_pkg::SEG_START[seg_ff + IDX_W'(1)])))
      else $error("segment search ended outside the segment");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (rem_ff < span_ff))
      else $error("divider remainder reached the span");

   a_zero_depth: assert property (@(posedge clock) disable iff (reset)
      (req_take && (req_cmd == fti_pkg::CMD_LOOKUP) && (req_depth_index == '0))
         |=> (state_ff == S_DONE) && (res_ff == '0))
      else $error("depth zero lookup did not answer zero");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) && out_vld_ff && rsp_stall |=> out_vld_ff && (state_ff == S_DONE))
      else $error("held response lost while a result waited");

endmodule
